/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/rmss_pkg.sv */
// ---------------------------------------------------------------------------
// rmss_pkg
// Types, codes and signature constants of the ROM mapper signature scanner.
// ---------------------------------------------------------------------------
package rmss_pkg;

   localparam int LIMIT_W = 24;
   localparam int COUNT_W = 25;
   localparam int NUM_FLAGS = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd32768;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // history fill levels that enable the signature compares
   localparam logic [2:0] HIST_FULL = 3'd4;
   localparam logic [2:0] HIST_PAIR = 3'd2;

   // byte signatures
   localparam logic [39:0] SIG_SOUND = 40'h3E9F32B080;
   localparam logic [23:0] SIG_6800  = 24'h320068;
   localparam logic [23:0] SIG_7000  = 24'h320070;
   localparam logic [23:0] SIG_7800  = 24'h320078;
   localparam logic [23:0] SIG_6000  = 24'h320060;

   // flag positions in the found vector
   localparam int FLAG_SOUND = 0;
   localparam int FLAG_6800  = 1;
   localparam int FLAG_7000  = 2;
   localparam int FLAG_7800  = 3;
   localparam int FLAG_6000  = 4;

   typedef enum logic [1:0] {
      GEN_UNKNOWN = 2'd0,
      GEN_SMALL   = 2'd1,
      GEN_LARGE   = 2'd2
   } gen_type;

   typedef enum logic [2:0] {
      MAP_UNKNOWN = 3'd0,
      MAP_PLAIN   = 3'd1,
      MAP_DEFAULT = 3'd2,
      MAP_SOUND   = 3'd3,
      MAP_16K     = 3'd4,
      MAP_8K      = 3'd5
   } map_type;

   typedef struct packed {
      gen_type generation;
      map_type mapper;
   } result_type;

endpackage

/* hw/rtl/rmss_scan.sv */
// ---------------------------------------------------------------------------
// rmss_scan
// Byte history, signature flags and byte count; classifies on the last word.
// ---------------------------------------------------------------------------
module rmss_scan import rmss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               has_byte,
   input  logic               last_byte,
   input  logic [LIMIT_W-1:0] plain_size_limit,
   output result_type         result
);

   logic [31:0]          recent_ff, recent_in, recent_scan;
   logic [2:0]           fill_ff, fill_in, fill_scan;
   logic [NUM_FLAGS-1:0] flags_ff, flags_in, flags_scan, hits;
   logic [COUNT_W-1:0]   count_ff, count_in, count_scan;
   logic [23:0]          last3;
   logic                 two_of_three;

   assign last3 = {recent_ff[15:0], data_byte};

   always_comb begin
      hits = '0;
      hits[FLAG_SOUND] = (fill_ff >= HIST_FULL) && ({recent_ff, data_byte} == SIG_SOUND);
      hits[FLAG_6800]  = (fill_ff >= HIST_PAIR) && (last3 == SIG_6800);
      hits[FLAG_7000]  = (fill_ff >= HIST_PAIR) && (last3 == SIG_7000);
      hits[FLAG_7800]  = (fill_ff >= HIST_PAIR) && (last3 == SIG_7800);
      hits[FLAG_6000]  = (fill_ff >= HIST_PAIR) && (last3 == SIG_6000);
   end

   // state as it stands after the word's byte, if any, is scanned
   always_comb begin
      recent_scan = recent_ff;
      fill_scan   = fill_ff;
      flags_scan  = flags_ff;
      count_scan  = count_ff;
      if (has_byte) begin
         recent_scan = {recent_ff[23:0], data_byte};
         flags_scan  = flags_ff | hits;
         if (fill_ff < HIST_FULL) begin
            fill_scan = fill_ff + 3'd1;
         end
         if (count_ff != COUNT_MAX) begin
            count_scan = count_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
         end
      end
   end

   // advance the state on an accepted word; start a new image after the last word
   always_comb begin
      recent_in = recent_ff;
      fill_in   = fill_ff;
      flags_in  = flags_ff;
      count_in  = count_ff;
      if (accept) begin
         if (last_byte) begin
            recent_in = '0;
            fill_in   = '0;
            flags_in  = '0;
            count_in  = '0;
         end else begin
            recent_in = recent_scan;
            fill_in   = fill_scan;
            flags_in  = flags_scan;
            count_in  = count_scan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         fill_ff   <= '0;
         flags_ff  <= '0;
         count_ff  <= '0;
      end else begin
         recent_ff <= recent_in;
         fill_ff   <= fill_in;
         flags_ff  <= flags_in;
         count_ff  <= count_in;
      end
   end

   assign two_of_three = (flags_scan[FLAG_6800] & flags_scan[FLAG_7000])
                       | (flags_scan[FLAG_6800] & flags_scan[FLAG_7800])
                       | (flags_scan[FLAG_7000] & flags_scan[FLAG_7800]);

   always_comb begin
      if (count_scan == '0) begin
         result.generation = GEN_UNKNOWN;
         result.mapper     = MAP_UNKNOWN;
      end else if (count_scan <= {1'b0, plain_size_limit}) begin
         result.generation = GEN_SMALL;
         result.mapper     = MAP_PLAIN;
      end else begin
         result.generation = GEN_LARGE;
         if (flags_scan[FLAG_SOUND]) begin
            result.mapper = MAP_SOUND;
         end else if (flags_scan[FLAG_6000] && flags_scan[FLAG_7000]) begin
            result.mapper = MAP_16K;
         end else if (two_of_three) begin
            result.mapper = MAP_8K;
         end else begin
            result.mapper = MAP_DEFAULT;
         end
      end
   end

endmodule

/* hw/rtl/rmss_outreg.sv */
// ---------------------------------------------------------------------------
// rmss_outreg
// Result register with valid/ready handshake toward the receiver.
// ---------------------------------------------------------------------------
module rmss_outreg import rmss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       slot_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_generation_code,
   output logic [2:0] rsp_mapper_code
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_generation_code = data_ff.generation;
   assign rsp_mapper_code     = data_ff.mapper;

endmodule

/* hw/rtl/rom_mapper_signature_scanner.sv */
// ---------------------------------------------------------------------------
// rom_mapper_signature_scanner
// Streams a cartridge image byte by byte and classifies its bank scheme.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one word per cycle while req_ready is high carries data_byte, has_byte and last_byte.
//            A word with has_byte set adds its byte to the current image;
//            a word with last_byte set closes the image and asks for a result.
//   rsp_*  : one result word per closed image: generation_code, mapper_code.
//   csr_*  : writes plain_size_limit (reset value 32768); always ready.
//            Write it only while no image result is outstanding.
// Timing: the result of a last word shows on rsp_* in the cycle after it is
//   accepted. Throughput: one word per cycle while req_ready is high; the
//   result is classified combinationally from the byte history and registered.
// Reset: synchronous; clears history, flags, count and the result valid flag,
//   and restores the size limit.
// Stall: while a result waits and rsp_ready is low, req_ready drops and
//   the scanner holds its state; it resumes the cycle the result is taken.
// ---------------------------------------------------------------------------
module rom_mapper_signature_scanner import rmss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // image words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_has_byte,
   input  logic               req_last_byte,
   // classification results
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_generation_code,
   output logic [2:0]         rsp_mapper_code,
   // size limit register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_plain_size_limit
);

   logic               accept;
   logic               slot_free;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   result_type         result;

   // take a word whenever the result register is empty or drains this cycle
   assign req_ready = slot_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // hold the limit until the next write
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_plain_size_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // scan the byte and, on the last word, classify the finished image
   rmss_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .has_byte         (req_has_byte),
      .last_byte        (req_last_byte),
      .plain_size_limit (limit_ff),
      .result           (result)
   );

   // register the classification for the receiver
   rmss_outreg u_outreg (
      .clock               (clock),
      .reset               (reset),
      .load                (accept && req_last_byte),
      .result              (result),
      .slot_free           (slot_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_generation_code (rsp_generation_code),
      .rsp_mapper_code     (rsp_mapper_code)
   );

endmodule

/* hw/rtl/rmss_checker.sv */
// ---------------------------------------------------------------------------
// rmss_checker
// Port-level checks of the scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rmss_checker import rmss_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_generation_code,
   input logic [2:0] rsp_mapper_code
);

   // no result survives a reset
   `ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

   // a closed image always yields a result on the next cycle
   `ASSERT_CLK(a_last_gives_result,
               req_valid && req_ready && req_last_byte |=> rsp_valid,
               "last word gave no result")

   // an empty result register never blocks the input
   `ASSERT_CLK(a_ready_when_empty, !rsp_valid |-> req_ready, "input stalled with no result pending")

   // generation and mapper codes agree with each other
   `ASSERT_CLK(a_code_pair,
               rsp_valid |->
                  ((rsp_generation_code == GEN_UNKNOWN && rsp_mapper_code == MAP_UNKNOWN) ||
                   (rsp_generation_code == GEN_SMALL && rsp_mapper_code == MAP_PLAIN) ||
                   (rsp_generation_code == GEN_LARGE && rsp_mapper_code >= MAP_DEFAULT &&
                    rsp_mapper_code <= MAP_8K)),
               "inconsistent result codes")

   // a stalled result holds
   `ASSERT_CLK(a_hold_stalled,
               rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_generation_code) &&
                  $stable(rsp_mapper_code),
               "stalled result changed")

endmodule

bind rom_mapper_signature_scanner rmss_checker u_checker (.*);

/* sim/rom_mapper_signature_scanner_tb.sv */
// ---------------------------------------------------------------------------
// rom_mapper_signature_scanner_tb
// Self-checking bench for the cartridge mapper signature scanner. A short
// scripted pass covers empty images, size boundaries and every signature.
// Long randomized passes follow, built mostly from real signatures
// with random filler, across several size limits. Both handshakes idle at
// random. A model of the image state predicts each classification that the
// script does not type in, and a scoreboard checks every result word in order.
// ---------------------------------------------------------------------------
module rom_mapper_signature_scanner_tb import rmss_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // signatures, as the scanner has to see them in the byte stream
   localparam logic [39:0] SOUND_ENABLE_SEQ = 40'h3E9F32B080;
   localparam logic [39:0] BANK_6800_WRITE  = 40'h0000320068;
   localparam logic [39:0] BANK_7000_WRITE  = 40'h0000320070;
   localparam logic [39:0] BANK_7800_WRITE  = 40'h0000320078;
   localparam logic [39:0] BANK_6000_WRITE  = 40'h0000320060;

   // positions in the model's found vector
   localparam int HIT_SOUND = 0;
   localparam int HIT_6800  = 1;
   localparam int HIT_7000  = 2;
   localparam int HIT_7800  = 3;
   localparam int HIT_6000  = 4;

   localparam logic [23:0] LIMIT_AT_RESET = 24'd32768;
   localparam logic [24:0] COUNT_CEILING  = 25'h1FFFFFF;

   localparam int SETTLE_CYCLES   = 4;    // result register plus margin
   localparam int TAIL_CYCLES     = 10;
   localparam int LONG_HOLD       = 400;  // receiver hold-off under pressure
   localparam int NUM_PHASES      = 8;
   localparam int WORDS_PER_PHASE = 245;  // 1960 counted words across all phases
   localparam int PRINT_CAP       = 40;

   typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
      logic       pinned;
      result_type pinned_result;
   } image_word_type;

   typedef struct packed {
      row_kind_type kind;
      logic [23:0]  limit_value;
      logic [7:0]   data_byte;
      logic         has_byte;
      logic         last_byte;
      logic         pinned;
      gen_type      pinned_gen;
      map_type      pinned_map;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_has_byte = 1'b0;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_generation_code;
   logic [2:0]         rsp_mapper_code;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_plain_size_limit = '0;

   // typed-in expectation that travels with the word on the request side
   logic               pinned_valid = 1'b0;
   result_type         pinned_result = '0;

   // image state model
   logic [23:0] size_limit_model = LIMIT_AT_RESET;
   logic [31:0] recent_bytes_model = '0;
   logic [2:0]  history_fill_model = '0;
   logic [4:0]  found_model = '0;
   logic [24:0] byte_count_model = '0;

   result_type     expected_results[$];
   image_word_type pending_words[$];
   int             mismatch_count = 0;
   int             images_checked = 0;
   bit             steady = 1'b0;
   bit             stall_request = 1'b0;

   // Scripted pass. Limit rows drain the block before the write; the
   // result is typed in only where it is obvious.
   localparam int SCRIPT_ROWS = 27;
   script_row_type directed_script [SCRIPT_ROWS] = '{
      // empty image right after reset
      '{ROW_WORD,  24'd0, 8'hA5, 1'b0, 1'b1, 1'b1, GEN_UNKNOWN, MAP_UNKNOWN},
      // one-byte images are plain under the reset limit
      '{ROW_WORD,  24'd0, 8'hFF, 1'b1, 1'b1, 1'b1, GEN_SMALL, MAP_PLAIN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b1, 1'b1, 1'b1, GEN_SMALL, MAP_PLAIN},
      // limit 0: every non-empty image is large
      '{ROW_LIMIT, 24'd0, 8'h00, 1'b0, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b1, 1'b1, 1'b1, GEN_LARGE, MAP_DEFAULT},
      // sound-chip sequence with an empty word in the middle of it
      '{ROW_WORD,  24'd0, 8'h3E, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h9F, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h5A, 1'b0, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h32, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'hB0, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h80, 1'b1, 1'b1, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      // both 16KB bank writes
      '{ROW_WORD,  24'd0, 8'h32, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h60, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h32, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h70, 1'b1, 1'b1, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      // two of the 8KB bank writes
      '{ROW_WORD,  24'd0, 8'h32, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h68, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h32, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h78, 1'b1, 1'b1, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      // largest limit; a closing word without a byte
      '{ROW_LIMIT, 24'hFFFFFF, 8'h00, 1'b0, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'hC3, 1'b1, 1'b0, 1'b0, GEN_UNKNOWN, MAP_UNKNOWN},
      '{ROW_WORD,  24'd0, 8'h3C, 1'b0, 1'b1, 1'b1, GEN_SMALL, MAP_PLAIN},
      '{ROW_WORD,  24'd0, 8'h00, 1'b0, 1'b1, 1'b1, GEN_UNKNOWN, MAP_UNKNOWN}
   };

   rom_mapper_signature_scanner u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_has_byte         (req_has_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_generation_code  (rsp_generation_code),
      .rsp_mapper_code      (rsp_mapper_code),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_plain_size_limit (csr_plain_size_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the image model by one accepted word. Returns 1 when the word
   // closes the image, with the classification in verdict.
   function automatic bit classify_image_word(input logic [7:0] data,
                                              input logic has, input logic last,
                                              output result_type verdict);
      logic [39:0] window;
      int          bank_8k_hits;
      window = {recent_bytes_model, data};
      verdict.generation = GEN_UNKNOWN;
      verdict.mapper = MAP_UNKNOWN;
      if (has) begin
         // a signature counts only once the history holds all its leading bytes
         if (history_fill_model >= 3'd4 && window == SOUND_ENABLE_SEQ)
            found_model[HIT_SOUND] = 1'b1;
         if (history_fill_model >= 3'd2) begin
            if (window[23:0] == BANK_6800_WRITE[23:0]) found_model[HIT_6800] = 1'b1;
            if (window[23:0] == BANK_7000_WRITE[23:0]) found_model[HIT_7000] = 1'b1;
            if (window[23:0] == BANK_7800_WRITE[23:0]) found_model[HIT_7800] = 1'b1;
            if (window[23:0] == BANK_6000_WRITE[23:0]) found_model[HIT_6000] = 1'b1;
         end
         recent_bytes_model = window[31:0];
         if (history_fill_model < 3'd4)
            history_fill_model++;
         if (byte_count_model != COUNT_CEILING)
            byte_count_model++;
      end
      if (!last)
         return 1'b0;
      if (byte_count_model == '0) begin
         verdict.generation = GEN_UNKNOWN;
         verdict.mapper = MAP_UNKNOWN;
      end else if (byte_count_model <= {1'b0, size_limit_model}) begin
         verdict.generation = GEN_SMALL;
         verdict.mapper = MAP_PLAIN;
      end else begin
         verdict.generation = GEN_LARGE;
         bank_8k_hits = int'(found_model[HIT_6800]) + int'(found_model[HIT_7000])
                      + int'(found_model[HIT_7800]);
         // priority: sound chip, then 16KB pair, then any two 8KB writes
         if (found_model[HIT_SOUND])
            verdict.mapper = MAP_SOUND;
         else if (found_model[HIT_6000] && found_model[HIT_7000])
            verdict.mapper = MAP_16K;
         else if (bank_8k_hits >= 2)
            verdict.mapper = MAP_8K;
         else
            verdict.mapper = MAP_DEFAULT;
      end
      // the next word starts a fresh image
      recent_bytes_model = '0;
      history_fill_model = '0;
      found_model = '0;
      byte_count_model = '0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Scoreboard: check result words first, then fold in the accepted request
   // word and the register write of this edge.
   always @(posedge clock) begin : scoreboard
      result_type want;
      result_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result word gen=%0d map=%0d",
                                         rsp_generation_code, rsp_mapper_code));
            end else begin
               want = expected_results.pop_front();
               if (rsp_generation_code !== want.generation)
                  report_mismatch($sformatf("image %0d generation_code %0d, want %s",
                                            images_checked, rsp_generation_code,
                                            want.generation.name()));
               if (rsp_mapper_code !== want.mapper)
                  report_mismatch($sformatf("image %0d mapper_code %0d, want %s",
                                            images_checked, rsp_mapper_code,
                                            want.mapper.name()));
            end
            images_checked++;
         end
         if (csr_valid && csr_ready)
            size_limit_model = csr_plain_size_limit;
         if (req_valid && req_ready) begin
            if (classify_image_word(req_data_byte, req_has_byte, req_last_byte, predicted))
               expected_results.push_back(pinned_valid ? pinned_result : predicted);
         end
      end
   end

   // Result side: random back-pressure, a clean stretch while steady, and
   // one long hold-off on request so the block fills and stalls its input.
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            hold_left = LONG_HOLD;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 33);
         end
      end
   end

   // Drop valid and let the clock run; n sets how long.
   task automatic hold_input(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Present one word and hold it until the block takes it.
   task automatic offer_word(input image_word_type w);
      req_valid <= 1'b1;
      req_data_byte <= w.data_byte;
      req_has_byte <= w.has_byte;
      req_last_byte <= w.last_byte;
      pinned_valid <= w.pinned;
      pinned_result <= w.pinned_result;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Write the size limit with the block idle: wait for every predicted result
   // and a settle margin first.
   task automatic set_size_limit(input logic [LIMIT_W-1:0] value);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_plain_size_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void queue_word(input logic [7:0] data, input logic has,
                                      input logic last);
      image_word_type w;
      w = '0;
      w.data_byte = data;
      w.has_byte = has;
      w.last_byte = last;
      pending_words.push_back(w);
   endfunction

   // Queue one image byte; now and then slip an empty word in ahead of it,
   // so signatures also span words that carry nothing.
   function automatic void queue_byte(input logic [7:0] data);
      if ($urandom_range(99) < 5)
         queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_word(data, 1'b1, 1'b0);
   endfunction

   // Queue a signature, most significant byte first; sometimes spoil one
   // byte so near-misses show up too.
   function automatic void queue_signature(input logic [39:0] seq, input int len);
      int spoil;
      logic [7:0] flip;
      spoil = ($urandom_range(99) < 15) ? int'($urandom_range(0, len - 1)) : -1;
      flip = 8'($urandom_range(1, 255));
      for (int k = len - 1; k >= 0; k--)
         queue_byte(seq[k*8 +: 8] ^ ((k == spoil) ? flip : 8'h00));
   endfunction

   // Build one image: mostly signatures in random filler, some pure noise.
   function automatic void build_image();
      int chunks;
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(0, 40)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
         chunks = $urandom_range(0, 6);
         repeat (chunks) begin
            case ($urandom_range(0, 5))
               0: repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
               1: queue_signature(SOUND_ENABLE_SEQ, 5);
               2: queue_signature(BANK_6800_WRITE, 3);
               3: queue_signature(BANK_7000_WRITE, 3);
               4: queue_signature(BANK_7800_WRITE, 3);
               default: queue_signature(BANK_6000_WRITE, 3);
            endcase
         end
      end
      // close it, half the time with one more byte on the closing word
      queue_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endfunction

   initial begin : stimulus
      image_word_type w;
      logic [23:0]    limit_value;
      int             counted;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scripted pass
      foreach (directed_script[i]) begin
         if (directed_script[i].kind == ROW_LIMIT) begin
            set_size_limit(directed_script[i].limit_value);
         end else begin
            w.data_byte = directed_script[i].data_byte;
            w.has_byte = directed_script[i].has_byte;
            w.last_byte = directed_script[i].last_byte;
            w.pinned = directed_script[i].pinned;
            w.pinned_result.generation = directed_script[i].pinned_gen;
            w.pinned_result.mapper = directed_script[i].pinned_map;
            if ($urandom_range(99) < 33)
               hold_input($urandom_range(1, 4));
            offer_word(w);
         end
      end

      // Random passes, one size limit each. A pass may end mid-image, so the
      // limit also changes between an image's bytes and its closing word.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: limit_value = 24'($urandom_range(0, 12));
            1: limit_value = 24'd0;
            2: limit_value = 24'($urandom_range(0, 20));
            3: limit_value = 24'hFFFFFF;
            4: limit_value = 24'($urandom_range(0, 30));
            5: limit_value = 24'($urandom);
            6: limit_value = 24'd1;
            default: limit_value = 24'($urandom_range(4, 20));
         endcase
         set_size_limit(limit_value);
         // pass 1 runs with no idling on either side
         steady = (phase == 1);
         if (phase == 2)
            stall_request = 1'b1;
         counted = 0;
         while (counted < WORDS_PER_PHASE) begin
            if (pending_words.size() == 0)
               build_image();
            w = pending_words.pop_front();
            if (!steady && $urandom_range(99) < 33)
               hold_input($urandom_range(1, 4));
            offer_word(w);
            if (w.has_byte || w.last_byte)
               counted++;
         end
      end
      steady = 1'b0;

      // close the image that is still open
      while (pending_words.size() != 0)
         offer_word(pending_words.pop_front());

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #3ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
